FILE: src/rhsv_pkg.sv
// Shared types and constants for the RGB to hue/saturation/brightness converter.
// No dependencies; every other file in src except rhsv_div imports this package.
package rhsv_pkg;

    localparam int QueueDepth = 4;

    localparam int HueNumW = 29;   // |diff| << 13
    localparam int HueDenW = 16;   // max - min
    localparam int SatNumW = 34;   // 196605 * min at most
    localparam int SatDenW = 18;   // r + g + b at most
    localparam int QuotW   = 17;   // largest quotient is 3 * 32768

    localparam logic [18:0] RECIP3     = 19'd349526;   // ceil(2^20 / 3)
    localparam logic [16:0] HUE_WRAP   = 17'h0C000;
    localparam logic [16:0] OFF_RED    = 17'h0C000;
    localparam logic [16:0] OFF_GREEN  = 17'h04000;
    localparam logic [16:0] OFF_BLUE   = 17'h08000;
    localparam logic [15:0] SAT_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_PLAIN     = 2'd0,
        MODE_INTENSITY = 2'd1,
        MODE_VALUE     = 2'd2,
        MODE_LIGHTNESS = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [HueNumW-1:0] hue_num;
        logic [HueDenW-1:0] hue_den;
        logic               hue_neg;
        sector_t            sector;
        logic [SatNumW-1:0] sat_num;
        logic [SatDenW-1:0] sat_den;
        mode_t              mode;
        logic [15:0]        lo;
        logic [15:0]        bright;
        logic [15:0]        alpha;
    } item_t;

    typedef struct packed {
        logic    neg;
        sector_t sector;
        logic    gray;
    } hue_tag_t;

    typedef struct packed {
        mode_t       mode;
        logic        zero;
        logic [15:0] lo;
        logic [15:0] bright;
        logic [15:0] alpha;
    } sat_tag_t;

    localparam int HueTagW = $bits(hue_tag_t);
    localparam int SatTagW = $bits(sat_tag_t);

endpackage

FILE: src/rgb16_to_hsv_modes.sv
// Top level of the RGB to hue/saturation/brightness converter with the mode register.
// Depends on rhsv_pkg, rhsv_front and rhsv_back.
//
// Takes one 16-bit RGBA pixel per cycle while s_ready is high, returns hue (0..0xBFFF),
// saturation and brightness in the mode held in mode_reg (plain, intensity, value,
// lightness; written from cfg_wdata), alpha copied. A pixel passes through the input
// queue, the divider pipes (17 restoring stages, one quotient bit each) and the output
// register. Throughput is one pixel per cycle unless stalled; the queue of QUEUE_DEPTH
// entries absorbs output stalls. Write the mode only while no pixel is in flight.
module rgb16_to_hsv_modes #(
    parameter int QUEUE_DEPTH = rhsv_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_red_in,
    input  logic [15:0] s_green_in,
    input  logic [15:0] s_blue_in,
    input  logic [15:0] s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_hue_out,
    output logic [15:0] m_sat_out,
    output logic [15:0] m_bright_out,
    output logic [15:0] m_alpha_out
);
    import rhsv_pkg::*;

    mode_t mode_reg;
    logic  q_valid, q_pop;
    item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
        end else if (cfg_wen) begin
            mode_reg <= mode_t'(cfg_wdata);
        end
    end

    rhsv_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .s_alpha_in (s_alpha_in),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    rhsv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue_out    (m_hue_out),
        .m_sat_out    (m_sat_out),
        .m_bright_out (m_bright_out),
        .m_alpha_out  (m_alpha_out)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue_out < 16'hC000))
        else $error("hue out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !q_valid))
        else $error("pipeline not empty after reset");

    a_stall_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !q_pop)
        else $error("queue popped while output stalled");

endmodule

FILE: src/rhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// Depends on nothing but its parameters.
module rhsv_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 18,
    parameter int Q_W   = 17,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q,
    output logic [TAG_W-1:0] out_tag
);
    localparam int CMP_W = DEN_W + Q_W;

    logic [NUM_W-1:0] rem_reg [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [TAG_W-1:0] tag_reg [0:Q_W];
    logic             vld_reg [0:Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= in_num;
            den_reg[0] <= in_den;
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int SH = Q_W - 1 - s;
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rext;
        logic             take;

        assign dsh  = CMP_W'(den_reg[s]) << SH;
        assign rext = CMP_W'(rem_reg[s]);
        assign take = (rext >= dsh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[s+1]   <= q_reg[s] | (take ? (Q_W'(1) << SH) : '0);
                tag_reg[s+1] <= tag_reg[s];
            end
        end

        if (s < Q_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1] <= take ? NUM_W'(rext - dsh) : rem_reg[s];
                    den_reg[s+1] <= den_reg[s];
                end
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_q     = q_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];

endmodule

FILE: src/rhsv_front.sv
// Front end: accepts pixels, finds max/min, sets up both divisions and queues the item.
// Depends on rhsv_pkg.
module rhsv_front #(
    parameter int DEPTH = rhsv_pkg::QueueDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rhsv_pkg::mode_t     mode,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_red_in,
    input  logic [15:0]         s_green_in,
    input  logic [15:0]         s_blue_in,
    input  logic [15:0]         s_alpha_in,
    output logic                q_valid,
    output rhsv_pkg::item_t     q_item,
    input  logic                q_pop
);
    import rhsv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [15:0] hi, lo, span, lval, ldiv, mx, my;
    logic [17:0] sum, lo3;
    logic [16:0] lsum;
    logic [36:0] prod3;
    item_t       item;

    item_t            mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;

    always_comb begin
        hi = s_red_in;
        lo = s_red_in;
        if (s_green_in > hi) hi = s_green_in;
        if (s_blue_in > hi)  hi = s_blue_in;
        if (s_green_in < lo) lo = s_green_in;
        if (s_blue_in < lo)  lo = s_blue_in;
    end

    assign sum   = 18'(s_red_in) + 18'(s_green_in) + 18'(s_blue_in);
    assign span  = hi - lo;
    assign lsum  = 17'(hi) + 17'(lo);
    assign lval  = lsum[16:1];
    assign ldiv  = lval[15] ? (16'hFFFF - lval) : lval;
    assign prod3 = 37'(sum) * 37'(RECIP3);
    assign lo3   = 18'(lo) + {1'b0, lo, 1'b0};

    always_comb begin
        item         = '0;
        item.mode    = mode;
        item.lo      = lo;
        item.alpha   = s_alpha_in;
        item.hue_den = span;

        // hue sector: max tested in red, green, blue order
        if (hi == s_red_in) begin
            item.sector = SEC_RED;
            mx = s_green_in;
            my = s_blue_in;
        end else if (hi == s_green_in) begin
            item.sector = SEC_GREEN;
            mx = s_blue_in;
            my = s_red_in;
        end else begin
            item.sector = SEC_BLUE;
            mx = s_red_in;
            my = s_green_in;
        end
        item.hue_neg = (mx < my);
        item.hue_num = {((mx < my) ? (my - mx) : (mx - my)), 13'b0};

        case (mode)
            MODE_INTENSITY: begin
                item.bright  = prod3[35:20];
                item.sat_num = {lo3, 16'b0} - 34'(lo3);
                item.sat_den = sum;
            end
            MODE_VALUE: begin
                item.bright  = hi;
                item.sat_num = 34'({span, 16'b0}) - 34'(span);
                item.sat_den = 18'(hi);
            end
            MODE_LIGHTNESS: begin
                item.bright  = lval;
                item.sat_num = 34'({span, 15'b0});
                item.sat_den = 18'(ldiv);
            end
            default: begin
                item.bright  = hi;
                item.sat_num = '0;
                item.sat_den = '0;
            end
        endcase
    end

    assign s_ready = (cnt_reg != CNT_W'(DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: src/rhsv_back.sv
// Back end: runs the hue and saturation divisions, finishes the result, holds it for transfer.
// Depends on rhsv_pkg and rhsv_div.
module rhsv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  rhsv_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_hue_out,
    output logic [15:0]         m_sat_out,
    output logic [15:0]         m_bright_out,
    output logic [15:0]         m_alpha_out
);
    import rhsv_pkg::*;

    logic                adv;
    hue_tag_t            hue_tag_in, hue_tag;
    sat_tag_t            sat_tag_in, sat_tag;
    logic                hue_vld, sat_vld;
    logic [QuotW-1:0]    hue_q, sat_q;
    logic [16:0]         hue_off, hue_sum, hue_wrapped;
    logic [15:0]         hue_next, sat_next;
    logic                m_valid_reg;
    logic [15:0]         hue_reg, sat_reg, bright_reg, alpha_reg;

    // advance the whole pipe whenever the output slot is free or being taken
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    assign hue_tag_in.neg    = q_item.hue_neg;
    assign hue_tag_in.sector = q_item.sector;
    assign hue_tag_in.gray   = (q_item.hue_den == '0);

    assign sat_tag_in.mode   = q_item.mode;
    assign sat_tag_in.zero   = (q_item.sat_den == '0);
    assign sat_tag_in.lo     = q_item.lo;
    assign sat_tag_in.bright = q_item.bright;
    assign sat_tag_in.alpha  = q_item.alpha;

    rhsv_div #(
        .NUM_W (HueNumW),
        .DEN_W (HueDenW),
        .Q_W   (QuotW),
        .TAG_W (HueTagW)
    ) u_hue_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (q_valid),
        .in_num    (q_item.hue_num),
        .in_den    (q_item.hue_den),
        .in_tag    (hue_tag_in),
        .out_valid (hue_vld),
        .out_q     (hue_q),
        .out_tag   (hue_tag)
    );

    rhsv_div #(
        .NUM_W (SatNumW),
        .DEN_W (SatDenW),
        .Q_W   (QuotW),
        .TAG_W (SatTagW)
    ) u_sat_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (q_valid),
        .in_num    (q_item.sat_num),
        .in_den    (q_item.sat_den),
        .in_tag    (sat_tag_in),
        .out_valid (sat_vld),
        .out_q     (sat_q),
        .out_tag   (sat_tag)
    );

    always_comb begin
        case (hue_tag.sector)
            SEC_GREEN: hue_off = OFF_GREEN;
            SEC_BLUE:  hue_off = OFF_BLUE;
            default:   hue_off = OFF_RED;
        endcase
        // quotient is at most 8192, so the offset keeps the sum positive
        hue_sum     = hue_tag.neg ? (hue_off - hue_q) : (hue_off + hue_q);
        hue_wrapped = (hue_sum >= HUE_WRAP) ? (hue_sum - HUE_WRAP) : hue_sum;
        hue_next    = hue_tag.gray ? '0 : hue_wrapped[15:0];
    end

    always_comb begin
        case (sat_tag.mode)
            MODE_INTENSITY: sat_next = sat_tag.zero ? '0 : 16'(17'(SAT_MAX) - sat_q);
            MODE_VALUE:     sat_next = sat_tag.zero ? '0 : sat_q[15:0];
            MODE_LIGHTNESS: begin
                if (sat_tag.zero) begin
                    sat_next = '0;
                end else begin
                    sat_next = sat_q[16] ? SAT_MAX : sat_q[15:0];
                end
            end
            default:        sat_next = sat_tag.lo;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= hue_vld && sat_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= sat_tag.bright;
            alpha_reg  <= sat_tag.alpha;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hue_out    = hue_reg;
    assign m_sat_out    = sat_reg;
    assign m_bright_out = bright_reg;
    assign m_alpha_out  = alpha_reg;

endmodule

FILE: dv/rgb16_to_hsv_modes_tb.sv
// Testbench for rgb16_to_hsv_modes: directed and random pixels across all brightness modes,
// with random gaps and output stalls, checked against an in-bench HSV predictor.
// Depends on rhsv_pkg and the RTL under src.
module rgb16_to_hsv_modes_tb;
    import rhsv_pkg::*;

    typedef struct {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] bright;
        logic [15:0] alpha;
    } hsv_pixel_t;

    class hsv_scoreboard;
        mode_t      mode;
        hsv_pixel_t expected_q[$];
        int         errors;

        function new();
            mode = MODE_PLAIN;
            errors = 0;
        endfunction

        // Predict the converted pixel for one accepted input pixel.
        function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                 logic [15:0] a);
            longint     hi, lo, sum, br, sat, hue, diff, off, den;
            hsv_pixel_t px;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            sum = longint'(r) + g + b;
            case (mode)
                MODE_INTENSITY: begin
                    br = sum / 3;
                    sat = (hi != 0 && sum != 0) ? 65535 - (196605 * lo) / sum : 0;
                end
                MODE_VALUE: begin
                    br = hi;
                    sat = (hi != 0) ? (65535 * (hi - lo)) / hi : 0;
                end
                MODE_LIGHTNESS: begin
                    br = (hi + lo) >> 1;
                    den = br[15] ? 65535 - br : br;
                    sat = (br == 65535 || den == 0) ? 0 : (32768 * (hi - lo)) / den;
                end
                default: begin
                    br = hi;
                    sat = lo;
                end
            endcase
            if (sat < 0) sat = 0;
            if (sat > 65535) sat = 65535;
            if (br > 65535) br = 65535;
            if (hi == lo) begin
                hue = 0;
            end else begin
                if (hi == r) begin
                    diff = longint'(g) - b;
                    off = OFF_RED;
                end else if (hi == g) begin
                    diff = longint'(b) - r;
                    off = OFF_GREEN;
                end else begin
                    diff = longint'(r) - g;
                    off = OFF_BLUE;
                end
                hue = ((diff * 8192) / (hi - lo) + off) % longint'(HUE_WRAP);
            end
            px.hue = hue[15:0];
            px.sat = sat[15:0];
            px.bright = br[15:0];
            px.alpha = a;
            expected_q.push_back(px);
        endfunction

        function void check_result(hsv_pixel_t got);
            hsv_pixel_t exp_px;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result hue=%h sat=%h bright=%h alpha=%h",
                         $time, got.hue, got.sat, got.bright, got.alpha);
                errors++;
                return;
            end
            exp_px = expected_q.pop_front();
            if (got.hue !== exp_px.hue) begin
                $display("%0t: hue expected %h actual %h", $time, exp_px.hue, got.hue);
                errors++;
            end
            if (got.sat !== exp_px.sat) begin
                $display("%0t: sat expected %h actual %h", $time, exp_px.sat, got.sat);
                errors++;
            end
            if (got.bright !== exp_px.bright) begin
                $display("%0t: bright expected %h actual %h", $time, exp_px.bright,
                         got.bright);
                errors++;
            end
            if (got.alpha !== exp_px.alpha) begin
                $display("%0t: alpha expected %h actual %h", $time, exp_px.alpha,
                         got.alpha);
                errors++;
            end
        endfunction
    endclass

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 25;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_red_in = '0;
    logic [15:0] s_green_in = '0;
    logic [15:0] s_blue_in = '0;
    logic [15:0] s_alpha_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_hue_out;
    logic [15:0] m_sat_out;
    logic [15:0] m_bright_out;
    logic [15:0] m_alpha_out;

    hsv_scoreboard sb = new();
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int idle_cycles = 0;

    rgb16_to_hsv_modes u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_alpha_in   (s_alpha_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue_out    (m_hue_out),
        .m_sat_out    (m_sat_out),
        .m_bright_out (m_bright_out),
        .m_alpha_out  (m_alpha_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: check each transfer, then draw the stall before the next one.
    int rx_stall = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result('{m_hue_out, m_sat_out, m_bright_out, m_alpha_out});
                rx_stall = rx_calm ? 0 : $urandom_range(0, 15);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              logic [15:0] a);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red_in <= r;
        s_green_in <= g;
        s_blue_in <= b;
        s_alpha_in <= a;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(r, g, b, a);
    endtask

    // Drop valid and hold off until every expected pixel is back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic set_mode(mode_t m);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [15:0] pick_channel(int kind, logic [15:0] base);
        case (kind)
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h0001;
                    3: return 16'hFFFE;
                    default: return 16'($urandom);
                endcase
            end
            2: return base + 16'($urandom_range(0, 4));
            3: return 16'($urandom_range(0, 7));
            default: return 16'($urandom_range(0, 1)) ? base : 16'($urandom);
        endcase
    endfunction

    task automatic send_random_pixel();
        int          kind;
        logic [15:0] base;
        kind = $urandom_range(0, 4);
        base = (kind == 2) ? 16'($urandom_range(0, 65531)) : 16'($urandom);
        send_pixel(pick_channel(kind, base), pick_channel(kind, base),
                   pick_channel(kind, base), 16'($urandom));
    endtask

    logic [15:0] corner_px [7][3] = '{
        '{16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h0001, 16'h0000, 16'h0000},
        '{16'h0003, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'hFFFF, 16'h0001},
        '{16'h0007, 16'h0002, 16'hFFFF}
    };
    mode_t mode_plan [8] = '{MODE_PLAIN, MODE_INTENSITY, MODE_VALUE, MODE_LIGHTNESS,
                             MODE_LIGHTNESS, MODE_VALUE, MODE_INTENSITY, MODE_PLAIN};

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner pixels once per mode: black, white, tiny spreads, ties, each sector.
        for (int m = 0; m < 4; m++) begin
            set_mode(mode_plan[m]);
            for (int i = 0; i < 7; i++)
                send_pixel(corner_px[i][0], corner_px[i][1], corner_px[i][2],
                           (i % 2) ? 16'hFFFF : 16'h0000);
            drain_results();
        end

        for (int p = 0; p < 8; p++) begin
            set_mode(mode_plan[p]);
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 4 == 2);
            for (int i = 0; i < 228; i++) begin
                if (i == 114) drain_results();
                send_random_pixel();
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
